FILE: rtl/core/drle_pkg.sv
// Shared types and constants for the delta plus run-length encoder.
// No dependencies; compiled before every other file of the block.
package drle_pkg;

    // Field widths
    localparam int SAMPLE_BITS = 16;
    localparam int COUNT_BITS  = 16;
    localparam int DELTA_BITS  = SAMPLE_BITS + 1;

    // Output queue sizing: room for two pushes per stored transaction
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int LEVEL_BITS  = $clog2(QUEUE_DEPTH + 1);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [DELTA_BITS-1:0]  delta_t;
    typedef logic        [COUNT_BITS-1:0]  count_t;
    typedef logic        [PTR_BITS-1:0]    ptr_t;
    typedef logic        [LEVEL_BITS-1:0]  level_t;

    localparam count_t COUNT_MAX = '1;

    // One (delta, length) result
    typedef struct packed {
        delta_t delta_value;
        count_t run_length;
        logic   final_run;
    } run_pair_t;

    // Push strobes from the merge stage to the output queue
    typedef struct packed {
        logic first;
        logic second;
    } push_t;

endpackage

FILE: rtl/core/drle_sample_if.sv
// Input channel of the encoder: one sample and its end-of-stream mark.
// Depends on drle_pkg.
interface drle_sample_if;
    import drle_pkg::*;

    logic    valid;
    logic    ready;
    sample_t sample;
    logic    end_of_stream;

    modport source (output valid, output sample, output end_of_stream, input ready);
    modport sink   (input valid, input sample, input end_of_stream, output ready);
endinterface

FILE: rtl/core/drle_run_if.sv
// Output channel of the encoder: one (delta, length) run pair.
// Depends on drle_pkg.
interface drle_run_if;
    import drle_pkg::*;

    logic   valid;
    logic   ready;
    delta_t delta_value;
    count_t run_length;
    logic   final_run;

    modport source (output valid, output delta_value, output run_length,
                    output final_run, input ready);
    modport sink   (input valid, input delta_value, input run_length,
                    input final_run, output ready);
endinterface

FILE: rtl/core/drle_merge.sv
// Delta and run merge stage: holds the previous sample and the open run,
// and produces up to two run pairs per sample. Depends on drle_pkg.
module drle_merge
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  drle_pkg::sample_t    sample,
    input  logic                 end_of_stream,
    output drle_pkg::push_t      push,
    output drle_pkg::run_pair_t  pair0,
    output drle_pkg::run_pair_t  pair1
);
    import drle_pkg::*;

    sample_t prev_sample_reg, prev_sample_next;
    delta_t  run_delta_reg,   run_delta_next;
    count_t  run_count_reg,   run_count_next;
    logic    run_open_reg,    run_open_next;

    delta_t    delta;
    logic      extend;
    logic      emit_prev;
    delta_t    merged_delta;
    count_t    merged_count;
    run_pair_t prev_pair;
    run_pair_t last_pair;

    // Difference against the previous sample, sign-extended by one bit
    assign delta = {sample[SAMPLE_BITS-1], sample}
                 - {prev_sample_reg[SAMPLE_BITS-1], prev_sample_reg};

    // Extend the open run unless the delta changes or the count is full
    assign extend    = run_open_reg && (delta == run_delta_reg)
                     && (run_count_reg != COUNT_MAX);
    assign emit_prev = run_open_reg && !extend;

    assign merged_delta = extend ? run_delta_reg : delta;
    assign merged_count = extend ? run_count_reg + count_t'(1) : count_t'(1);

    // Build both candidate pairs
    always_comb
    begin
        prev_pair.delta_value = run_delta_reg;
        prev_pair.run_length  = run_count_reg;
        prev_pair.final_run   = 1'b0;
        last_pair.delta_value = merged_delta;
        last_pair.run_length  = merged_count;
        last_pair.final_run   = 1'b1;
    end

    // Order the pushes: the closed run first, then the flushed run
    always_comb
    begin
        push.first  = fire && (emit_prev || end_of_stream);
        push.second = fire && emit_prev && end_of_stream;
        pair0       = emit_prev ? prev_pair : last_pair;
        pair1       = last_pair;
    end

    // Next state: clear everything at stream end
    always_comb
    begin
        prev_sample_next = prev_sample_reg;
        run_delta_next   = run_delta_reg;
        run_count_next   = run_count_reg;
        run_open_next    = run_open_reg;
        if (fire)
        begin
            if (end_of_stream)
            begin
                prev_sample_next = '0;
                run_delta_next   = '0;
                run_count_next   = '0;
                run_open_next    = 1'b0;
            end
            else
            begin
                prev_sample_next = sample;
                run_delta_next   = merged_delta;
                run_count_next   = merged_count;
                run_open_next    = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_sample_reg <= '0;
            run_delta_reg   <= '0;
            run_count_reg   <= '0;
            run_open_reg    <= 1'b0;
        end
        else
        begin
            prev_sample_reg <= prev_sample_next;
            run_delta_reg   <= run_delta_next;
            run_count_reg   <= run_count_next;
            run_open_reg    <= run_open_next;
        end
    end

    // A second pair only ever follows a first
    assert property (@(posedge clk) disable iff (!rst_n)
        push.second |-> push.first)
        else $error("drle_merge: second push without first");

    // Stream end closes the run
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && end_of_stream) |=> (!run_open_reg && run_count_reg == '0))
        else $error("drle_merge: run left open after stream end");

    // Any other sample leaves a non-empty open run
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !end_of_stream) |=> (run_open_reg && run_count_reg != '0))
        else $error("drle_merge: empty run after sample");

endmodule

FILE: rtl/core/drle_fifo.sv
// Small output queue of run pairs: two writes and one read per cycle.
// Depends on drle_pkg.
module drle_fifo
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  drle_pkg::push_t      push,
    input  drle_pkg::run_pair_t  pair0,
    input  drle_pkg::run_pair_t  pair1,
    input  logic                 pop,
    output drle_pkg::run_pair_t  head,
    output logic                 not_empty,
    output logic                 room
);
    import drle_pkg::*;

    run_pair_t slot_reg [QUEUE_DEPTH];
    ptr_t      wr_ptr_reg, wr_ptr_next;
    ptr_t      rd_ptr_reg, rd_ptr_next;
    level_t    level_reg,  level_next;
    ptr_t      wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + ptr_t'(1);

    // Status from registered level only
    assign not_empty = (level_reg != '0);
    assign room      = (level_reg <= level_t'(QUEUE_DEPTH - 2));
    assign head      = slot_reg[rd_ptr_reg];

    // Advance pointers and level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + ptr_t'(push.first) + ptr_t'(push.second);
        rd_ptr_next = rd_ptr_reg + ptr_t'(pop);
        level_next  = level_reg + level_t'(push.first) + level_t'(push.second)
                    - level_t'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // Store payload; no reset needed
    always_ff @(posedge clk)
    begin
        if (push.first)
        begin
            slot_reg[wr_ptr_reg] <= pair0;
        end
        if (push.second)
        begin
            slot_reg[wr_ptr_plus1] <= pair1;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= level_t'(QUEUE_DEPTH))
        else $error("drle_fifo: level beyond depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        push.first |-> room)
        else $error("drle_fifo: push without room");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("drle_fifo: pop from empty queue");

endmodule

FILE: rtl/core/delta_rle_encoder_top.sv
// Top level of the delta plus run-length encoder.
// Depends on drle_pkg, drle_sample_if, drle_run_if, drle_merge, drle_fifo.
//
// Usage:
//   samples : sink channel, one signed sample per transaction; end_of_stream
//             marks the last sample and flushes the open run.
//   runs    : source channel, one (delta_value, run_length, final_run) pair
//             per transaction; final_run is set on the pair closing a stream.
//   The first delta of each stream is the sample itself. A run that reaches
//   the maximum count is sent and a new run of length one begins.
// Path: a pair caused by a sample passes the input register, then the merge
//   into the output queue, and is offered on runs from the queue head; it
//   moves when runs.ready is high.
// Throughput: one sample per cycle while the output queue has room; the runs
//   channel moves one pair per cycle, so a sample closing two runs costs two
//   pair transfers, absorbed by a four-entry output queue.
// Stall: when runs.ready is low the queue fills; samples.ready drops once
//   the queue cannot take two more pairs, with one sample held in the input
//   register. No pair is lost or repeated.
// Reset: rst_n clears the open run, the previous sample and the queue;
//   samples.ready is high right after reset.
module delta_rle_encoder_top
(
    input  logic          clk,
    input  logic          rst_n,
    drle_sample_if.sink   samples,
    drle_run_if.source    runs
);
    import drle_pkg::*;

    logic      in_valid_reg;
    sample_t   in_sample_reg;
    logic      in_eos_reg;
    logic      advance;
    logic      room;
    logic      not_empty;
    push_t     push;
    run_pair_t pair0;
    run_pair_t pair1;
    run_pair_t head;

    // Move the held sample into the merge stage when the queue has room
    assign advance       = in_valid_reg && room;
    assign samples.ready = !in_valid_reg || room;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (samples.valid && samples.ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (samples.valid && samples.ready)
        begin
            in_sample_reg <= samples.sample;
            in_eos_reg    <= samples.end_of_stream;
        end
    end

    drle_merge u_merge
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (advance),
        .sample        (in_sample_reg),
        .end_of_stream (in_eos_reg),
        .push          (push),
        .pair0         (pair0),
        .pair1         (pair1)
    );

    drle_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pair0     (pair0),
        .pair1     (pair1),
        .pop       (runs.valid && runs.ready),
        .head      (head),
        .not_empty (not_empty),
        .room      (room)
    );

    // Drive the result channel from the queue head
    assign runs.valid       = not_empty;
    assign runs.delta_value = head.delta_value;
    assign runs.run_length  = head.run_length;
    assign runs.final_run   = head.final_run;

endmodule

FILE: verif/drle_pair_checker.sv
// Run-pair checker for the delta plus run-length encoder: predicts the pairs
// from observed sample transactions and compares them with the runs channel.
// Depends on drle_pkg, drle_sample_if, drle_run_if.
module drle_pair_checker
    import drle_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    drle_sample_if  samples,
    drle_run_if     runs,
    output int      mismatch_count,
    output int      runs_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Predictor state: mirrors the encoder's open run and previous sample
    sample_t   last_sample;
    delta_t    open_delta;
    count_t    open_count;
    logic      run_is_open;
    run_pair_t pending_runs[$];

    // Append one predicted pair at the tail of the expected queue
    function automatic void queue_pair(input delta_t d, input count_t n,
                                       input logic is_final);
        run_pair_t p;
        p.delta_value = d;
        p.run_length  = n;
        p.final_run   = is_final;
        pending_runs.insert(pending_runs.size(), p);
    endfunction

    // Merge one sample into the open run and queue the pairs it closes
    function automatic void predict_runs(input sample_t cur, input logic eos);
        delta_t step;
        step = {cur[SAMPLE_BITS-1], cur} - {last_sample[SAMPLE_BITS-1], last_sample};
        last_sample = cur;
        if (run_is_open && step == open_delta && open_count != COUNT_MAX)
        begin
            open_count = open_count + count_t'(1);
        end
        else
        begin
            // Different delta or full run: close the current run first
            if (run_is_open)
            begin
                queue_pair(open_delta, open_count, 1'b0);
            end
            open_delta  = step;
            open_count  = count_t'(1);
            run_is_open = 1'b1;
        end
        // Flush the open run at end of stream and restart from zero
        if (eos)
        begin
            queue_pair(open_delta, open_count, 1'b1);
            run_is_open = 1'b0;
            open_delta  = '0;
            open_count  = '0;
            last_sample = '0;
        end
    endfunction

    // Compare each run transaction against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        run_pair_t want;
        if (!rst_n)
        begin
            last_sample    = '0;
            open_delta     = '0;
            open_count     = '0;
            run_is_open    = 1'b0;
            pending_runs.delete();
            mismatch_count = 0;
        end
        else
        begin
            if (runs.valid && runs.ready)
            begin
                if (pending_runs.size() == 0)
                begin
                    $error("unexpected run pair: delta_value %0d run_length %0d final_run %0d",
                           runs.delta_value, runs.run_length, runs.final_run);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_runs.pop_front();
                    if (runs.delta_value !== want.delta_value)
                    begin
                        $error("delta_value mismatch: expected %0d, actual %0d",
                               want.delta_value, runs.delta_value);
                        mismatch_count++;
                    end
                    if (runs.run_length !== want.run_length)
                    begin
                        $error("run_length mismatch: expected %0d, actual %0d",
                               want.run_length, runs.run_length);
                        mismatch_count++;
                    end
                    if (runs.final_run !== want.final_run)
                    begin
                        $error("final_run mismatch: expected %0b, actual %0b",
                               want.final_run, runs.final_run);
                        mismatch_count++;
                    end
                end
            end
            if (samples.valid && samples.ready)
            begin
                predict_runs(samples.sample, samples.end_of_stream);
            end
        end
        runs_pending = pending_runs.size();
    end

endmodule

FILE: verif/tb_delta_rle_encoder_top.sv
// Testbench top for delta_rle_encoder_top: drives sample streams with bursty
// timing, stalls the runs channel, and reports the verdict from the checker.
// Depends on drle_pkg, drle_sample_if, drle_run_if, drle_pair_checker and the RTL.
module tb_delta_rle_encoder_top;
    timeunit 1ns;
    timeprecision 1ps;
    import drle_pkg::*;

    // Shapes of the random sample segments
    typedef enum int {HOLD_LEVEL, RAMP_SMALL, RAMP_WIDE, NOISE, SWING_RAILS} pattern_t;

    localparam int RANDOM_ITEMS = 1600;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int   mismatch_count;
    int   runs_pending;
    int   burst_left   = 0;
    int   random_items = 0;

    // Receiver stall generator state
    int          segment_left  = 0;
    int          ready_mode    = 0;
    logic [31:0] stall_pattern = '1;

    drle_sample_if sample_ch ();
    drle_run_if    run_ch ();

    delta_rle_encoder_top DUT
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sample_ch),
        .runs    (run_ch)
    );

    drle_pair_checker u_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .samples        (sample_ch),
        .runs           (run_ch),
        .mismatch_count (mismatch_count),
        .runs_pending   (runs_pending)
    );

    always #4 clk = ~clk;

    // Abort a hung run
    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Stall the receiver: segments of always-ready, coin-flip, heavy stall,
    // or a rotating bit pattern
    always @(posedge clk)
    begin
        if (segment_left == 0)
        begin
            segment_left  <= $urandom_range(8, 64);
            ready_mode    <= $urandom_range(0, 3);
            stall_pattern <= $urandom;
        end
        else
        begin
            segment_left  <= segment_left - 1;
            stall_pattern <= {stall_pattern[0], stall_pattern[31:1]};
        end
        case (ready_mode)
            0:       run_ch.ready <= 1'b1;
            1:       run_ch.ready <= 1'($urandom_range(0, 1));
            2:       run_ch.ready <= ($urandom_range(0, 3) == 0);
            default: run_ch.ready <= stall_pattern[0];
        endcase
    end

    // Send one sample transaction, sometimes inserting a gap at a burst boundary
    task automatic push_sample(input sample_t value, input logic eos);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 48);
            if (gap != 0)
            begin
                sample_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        sample_ch.valid         <= 1'b1;
        sample_ch.sample        <= value;
        sample_ch.end_of_stream <= eos;
        do
            @(posedge clk);
        while (!sample_ch.ready);
    endtask

    // Hold the sender until every predicted pair has been received
    task automatic wait_drained();
        sample_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (runs_pending != 0);
        @(posedge clk);
    endtask

    // Send one stream built from segments of random shape, ending in eos
    task automatic send_random_stream();
        int       len;
        int       seg;
        int       sent;
        pattern_t shape;
        sample_t  value;
        sample_t  step;
        len   = $urandom_range(1, 40);
        value = sample_t'($urandom);
        sent  = 0;
        while (sent < len)
        begin
            shape = pattern_t'($urandom_range(0, 4));
            seg   = $urandom_range(1, 12);
            case (shape)
                HOLD_LEVEL: step = '0;
                RAMP_SMALL: step = sample_t'($urandom_range(0, 6)) - sample_t'(3);
                default:    step = sample_t'($urandom);
            endcase
            for (int k = 0; k < seg && sent < len; k++)
            begin
                if (shape == NOISE)
                    value = sample_t'($urandom);
                else if (shape == SWING_RAILS)
                    value = (value == 16'sh7FFF) ? 16'sh8000 : 16'sh7FFF;
                else
                    value = value + step;
                push_sample(value, sent == len - 1);
                sent++;
                random_items++;
            end
        end
    endtask

    // Stimulus and verdict
    initial
    begin
        sample_ch.valid         <= 1'b0;
        sample_ch.sample        <= '0;
        sample_ch.end_of_stream <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Rail values: first delta is the sample, then extreme deltas both ways
        push_sample(16'sh7FFF, 1'b0);
        push_sample(16'sh8000, 1'b0);
        push_sample(16'sh7FFF, 1'b0);
        push_sample(16'sh7FFF, 1'b0);
        push_sample(16'sh7FFF, 1'b1);
        // Single-sample streams
        push_sample(16'sh8000, 1'b1);
        push_sample(16'sh0000, 1'b1);
        // Ramp merged into one run
        push_sample(16'sd5, 1'b0);
        push_sample(16'sd10, 1'b0);
        push_sample(16'sd15, 1'b0);
        push_sample(16'sd20, 1'b1);
        // End of stream on a new delta: two pairs from one sample
        push_sample(16'sd7, 1'b0);
        push_sample(16'sd7, 1'b0);
        push_sample(16'sd9, 1'b1);
        // Negative ramp then a flat step
        push_sample(-16'sd1, 1'b0);
        push_sample(-16'sd2, 1'b0);
        push_sample(-16'sd3, 1'b0);
        push_sample(-16'sd3, 1'b1);
        wait_drained();

        // Random streams, pausing now and then until the queue drains
        while (random_items < RANDOM_ITEMS)
        begin
            send_random_stream();
            if ($urandom_range(0, 39) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (10) @(posedge clk);
        @(negedge clk);
        if (mismatch_count == 0 && runs_pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/drle_pkg.sv
rtl/core/drle_sample_if.sv
rtl/core/drle_run_if.sv
rtl/core/drle_merge.sv
rtl/core/drle_fifo.sv
rtl/core/delta_rle_encoder_top.sv
verif/drle_pair_checker.sv
verif/tb_delta_rle_encoder_top.sv
